>>> sv/rtdc_pkg.sv
`timescale 1ns / 1ps
package rtdc_pkg;

   localparam int RegCount = 2;
   localparam logic [0:0] REG_REFERENCE_OHMS = 1'd0;
   localparam logic [0:0] REG_NOMINAL_OHMS = 1'd1;

   localparam logic [15:0] REFERENCE_RESET = 16'd430;
   localparam logic [15:0] NOMINAL_RESET = 16'd100;

   // datapath operations
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_CAPTURE = 4'd1;
   localparam logic [3:0] OP_MUL_RATIO = 4'd2;
   localparam logic [3:0] OP_DIV_RATIO_LOAD = 4'd3;
   localparam logic [3:0] OP_DIV_STEP = 4'd4;
   localparam logic [3:0] OP_DISC_MUL = 4'd5;
   localparam logic [3:0] OP_DISC_SUB = 4'd6;
   localparam logic [3:0] OP_SQRT_STEP = 4'd7;
   localparam logic [3:0] OP_MAG_MUL = 4'd8;
   localparam logic [3:0] OP_TEMP_RECIP = 4'd9;
   localparam logic [3:0] OP_COMMIT = 4'd10;

   localparam logic [31:0] RATIO_CAP = 32'h8000_0000;
   localparam logic [27:0] DISC_SLOPE = 28'd231000000;
   localparam logic [59:0] DISC_BASE_SHIFTED = 60'd1758480889 << 24;
   localparam logic [27:0] A_UNITS = 28'd160083968;
   // 1000 / 11550 reduced to 20 / 231, half of 231 * 4096 for rounding
   localparam logic [4:0]  T_SCALE = 5'd20;
   localparam logic [18:0] T_ROUND = 19'd473088;
   // ceil(2^39 / 231), exact floor division by 231 for operands below 2^31
   localparam logic [31:0] T_RECIP = 32'd2379895299;
   localparam logic [31:0] T_MAX_MAG = 32'd262143;
   localparam logic [31:0] T_MIN_MAG = 32'd262144;

   localparam int DIV_STEPS = 32;
   localparam int SQRT_STEPS = 28;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic compute;
   } sts_type;

endpackage

>>> sv/rtdc_if.sv
`timescale 1ns / 1ps
interface rtdc_req_if;
   logic        valid;
   logic        ready;
   logic        data_ready;
   logic [15:0] rtd_word;
   logic [7:0]  fault_status;
   modport source (output valid, data_ready, rtd_word, fault_status, input ready);
   modport sink (input valid, data_ready, rtd_word, fault_status, output ready);
endinterface

interface rtdc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [18:0] temperature;
   logic               fresh;
   logic               clear_request;
   logic [7:0]         held_fault_status;
   modport source (output valid, temperature, fresh, clear_request, held_fault_status,
      input ready);
   modport sink (input valid, temperature, fresh, clear_request, held_fault_status,
      output ready);
endinterface

interface rtdc_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/rtdc_div.sv
`timescale 1ns / 1ps
module rtdc_div (
   input  logic        clock,
   input  logic        load,
   input  logic        step,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient,
   output logic        overflow
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] shf_ff, shf_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        ovf_ff, ovf_in;
   logic [32:0] trial;
   logic        ge;

   always_comb begin
      trial = {rem_ff, shf_ff[31]};
      ge = trial >= {1'b0, dsr_ff};
      rem_in = rem_ff;
      shf_in = shf_ff;
      dsr_in = dsr_ff;
      ovf_in = ovf_ff;
      if (load) begin
         rem_in = dividend[63:32];
         shf_in = dividend[31:0];
         dsr_in = divisor;
         ovf_in = dividend[63:32] >= divisor;
      end else if (step) begin
         rem_in = ge ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
         shf_in = {shf_ff[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dsr_ff <= dsr_in;
      ovf_ff <= ovf_in;
   end

   assign quotient = shf_ff;
   assign overflow = ovf_ff;

endmodule

>>> sv/rtdc_datapath.sv
`timescale 1ns / 1ps
module rtdc_datapath #(
   parameter int TEMP_FRAC_BITS = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  rtdc_pkg::cmd_type  cmd,
   output rtdc_pkg::sts_type  sts,
   input  logic               in_data_ready,
   input  logic [15:0]        in_rtd_word,
   input  logic [7:0]         in_fault_status,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic signed [18:0] out_temperature,
   output logic               out_fresh,
   output logic               out_clear_request,
   output logic [7:0]         out_held_fault_status
);

   logic [15:0] ref_ff, nom_ff;
   logic        rdy_ff, flt_ff;
   logic [14:0] code_ff;
   logic [7:0]  fstat_ff;
   logic [30:0] prod_ff;
   logic [59:0] big_ff;
   logic [55:0] val_ff;
   logic [29:0] srem_ff;
   logic [27:0] root_ff;
   logic        neg_ff;
   logic [31:0] mag_ff;
   logic [24:0] tq_ff;
   logic signed [18:0] held_ff;
   logic [7:0]  held_fs_ff;
   logic signed [18:0] tout_ff;
   logic        fresh_ff, clr_ff;
   logic [7:0]  fsout_ff;

   logic        div_load;
   logic [63:0] div_dividend;
   logic [31:0] div_divisor;
   logic [31:0] quo;
   logic        ovf;
   logic [31:0] xq;
   logic [59:0] disc;
   logic [31:0] sq_trial, sq_cand;
   logic        sq_ge;
   logic        diff_neg;
   logic [28:0] abs_diff;
   logic [63:0] mag_num;
   logic [63:0] rec_prod;
   logic signed [18:0] temp_new;
   logic        compute;

   assign sts.compute = in_data_ready & ~in_rtd_word[0];
   assign compute = rdy_ff & ~flt_ff;

   assign div_load = cmd.op == rtdc_pkg::OP_DIV_RATIO_LOAD;
   assign div_dividend = 64'(prod_ff) << 24;
   assign div_divisor = {16'd0, nom_ff};

   rtdc_div u_div (
      .clock    (clock),
      .load     (div_load),
      .step     (cmd.op == rtdc_pkg::OP_DIV_STEP),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (quo),
      .overflow (ovf)
   );

   always_comb begin
      // ratio clamp, zero nominal lands here through the overflow flag
      xq = (ovf || quo > rtdc_pkg::RATIO_CAP) ? rtdc_pkg::RATIO_CAP : quo;
      disc = (big_ff > rtdc_pkg::DISC_BASE_SHIFTED) ? 60'd0
         : rtdc_pkg::DISC_BASE_SHIFTED - big_ff;
      sq_cand = {srem_ff, val_ff[55:54]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge = sq_cand >= sq_trial;
      diff_neg = root_ff > rtdc_pkg::A_UNITS;
      abs_diff = diff_neg ? 29'(root_ff - rtdc_pkg::A_UNITS)
         : 29'(rtdc_pkg::A_UNITS - root_ff);
      // rounded numerator, the 4096 part of the divisor taken off by a shift
      mag_num = ((64'(abs_diff) * 64'(rtdc_pkg::T_SCALE)) << TEMP_FRAC_BITS)
         + 64'(rtdc_pkg::T_ROUND);
      rec_prod = 64'(mag_ff) * 64'(rtdc_pkg::T_RECIP);
      if (neg_ff)
         temp_new = (tq_ff > rtdc_pkg::T_MIN_MAG) ? -19'sd262144 : 19'(-tq_ff);
      else
         temp_new = (tq_ff > rtdc_pkg::T_MAX_MAG) ? 19'sd262143 : 19'(tq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= rtdc_pkg::REFERENCE_RESET;
         nom_ff <= rtdc_pkg::NOMINAL_RESET;
         held_ff <= '0;
         held_fs_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               rtdc_pkg::REG_REFERENCE_OHMS: ref_ff <= csr_data;
               rtdc_pkg::REG_NOMINAL_OHMS: nom_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.op == rtdc_pkg::OP_COMMIT && rdy_ff) begin
            held_fs_ff <= fstat_ff;
            if (compute)
               held_ff <= temp_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         rtdc_pkg::OP_CAPTURE: begin
            rdy_ff <= in_data_ready;
            flt_ff <= in_rtd_word[0];
            code_ff <= in_rtd_word[15:1];
            fstat_ff <= in_fault_status;
         end
         rtdc_pkg::OP_MUL_RATIO: prod_ff <= code_ff * ref_ff;
         rtdc_pkg::OP_DISC_MUL: big_ff <= rtdc_pkg::DISC_SLOPE * xq;
         rtdc_pkg::OP_DISC_SUB: begin
            val_ff <= disc[55:0];
            srem_ff <= '0;
            root_ff <= '0;
         end
         rtdc_pkg::OP_SQRT_STEP: begin
            val_ff <= {val_ff[53:0], 2'b00};
            srem_ff <= sq_ge ? 30'(sq_cand - sq_trial) : sq_cand[29:0];
            root_ff <= {root_ff[26:0], sq_ge};
         end
         rtdc_pkg::OP_MAG_MUL: begin
            neg_ff <= diff_neg;
            mag_ff <= mag_num[43:12];
         end
         // divide by 231 through the reciprocal, shift of 39
         rtdc_pkg::OP_TEMP_RECIP: tq_ff <= rec_prod[63:39];
         rtdc_pkg::OP_COMMIT: begin
            tout_ff <= compute ? temp_new : held_ff;
            fresh_ff <= compute;
            clr_ff <= rdy_ff & flt_ff;
            fsout_ff <= rdy_ff ? fstat_ff : held_fs_ff;
         end
         default: ;
      endcase
   end

   assign out_temperature = tout_ff;
   assign out_fresh = fresh_ff;
   assign out_clear_request = clr_ff;
   assign out_held_fault_status = fsout_ff;

endmodule

>>> sv/rtdc_ctrl.sv
`timescale 1ns / 1ps
module rtdc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rtdc_pkg::sts_type sts,
   output rtdc_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL = 4'd1;
   localparam logic [3:0] S_DIVL = 4'd2;
   localparam logic [3:0] S_DIV = 4'd3;
   localparam logic [3:0] S_DMUL = 4'd4;
   localparam logic [3:0] S_DSUB = 4'd5;
   localparam logic [3:0] S_SQRT = 4'd6;
   localparam logic [3:0] S_MAG = 4'd7;
   localparam logic [3:0] S_RECIP = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      vld_in = vld_ff & ~rsp_ready;
      cmd.op = rtdc_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = rtdc_pkg::OP_CAPTURE;
               state_in = sts.compute ? S_MUL : S_DONE;
            end
         end
         S_MUL: begin
            cmd.op = rtdc_pkg::OP_MUL_RATIO;
            state_in = S_DIVL;
         end
         S_DIVL: begin
            cmd.op = rtdc_pkg::OP_DIV_RATIO_LOAD;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = rtdc_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(rtdc_pkg::DIV_STEPS - 1))
               state_in = S_DMUL;
         end
         S_DMUL: begin
            cmd.op = rtdc_pkg::OP_DISC_MUL;
            state_in = S_DSUB;
         end
         S_DSUB: begin
            cmd.op = rtdc_pkg::OP_DISC_SUB;
            cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = rtdc_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(rtdc_pkg::SQRT_STEPS - 1))
               state_in = S_MAG;
         end
         S_MAG: begin
            cmd.op = rtdc_pkg::OP_MAG_MUL;
            state_in = S_RECIP;
         end
         S_RECIP: begin
            cmd.op = rtdc_pkg::OP_TEMP_RECIP;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!vld_ff || rsp_ready) begin
               cmd.op = rtdc_pkg::OP_COMMIT;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff;

endmodule

>>> sv/rtd_to_temperature_converter.sv
`timescale 1ns / 1ps
// Converts one RTD converter poll per request into a temperature in units of
// 2^-TEMP_FRAC_BITS degrees C by inverting the Callendar-Van Dusen quadratic.
// A ready, fault-free request runs from acceptance to the output register,
// waiting in the last state for that register to free up: the resistance ratio
// goes through a 32-step restoring divider, the square root of the
// discriminant takes 28 one-bit steps and the final scaling is a reciprocal
// multiply. Polls that are not ready or carry the fault flag skip the
// maths. A new request is taken as soon as the previous one has reached the
// output register, even if that response has not yet been taken. Registers:
// 0 reference ohms, 1 nominal ohms; write them only while the block is idle.
module rtd_to_temperature_converter #(
   parameter int TEMP_FRAC_BITS = 6
) (
   input logic       clock,
   input logic       reset,
   rtdc_req_if.sink   req_chan,
   rtdc_rsp_if.source rsp_chan,
   rtdc_csr_if.sink   csr_chan
);

   rtdc_pkg::cmd_type cmd;
   rtdc_pkg::sts_type sts;

   assign csr_chan.ready = 1'b1;

   rtdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtdc_datapath #(
      .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .in_data_ready         (req_chan.data_ready),
      .in_rtd_word           (req_chan.rtd_word),
      .in_fault_status       (req_chan.fault_status),
      .csr_write             (csr_chan.valid),
      .csr_index             (csr_chan.index),
      .csr_data              (csr_chan.data),
      .out_temperature       (rsp_chan.temperature),
      .out_fresh             (rsp_chan.fresh),
      .out_clear_request     (rsp_chan.clear_request),
      .out_held_fault_status (rsp_chan.held_fault_status)
   );

endmodule

>>> test/tb_rtd_to_temperature_converter.sv
`timescale 1ns / 1ps
module tb_rtd_to_temperature_converter;

   localparam int FRAC_BITS = 6;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic signed [18:0] temperature;
      logic               fresh;
      logic               clear_request;
      logic [7:0]         held_fault_status;
   } reading_type;

   class reading_scoreboard;
      logic [15:0]        reference_ohms;
      logic [15:0]        nominal_ohms;
      logic signed [18:0] held_temperature;
      logic [7:0]         stored_fault_status;
      reading_type        pending[$];
      int                 mismatches;

      function void clear_state();
         reference_ohms = rtdc_pkg::REFERENCE_RESET;
         nominal_ohms = rtdc_pkg::NOMINAL_RESET;
         held_temperature = '0;
         stored_fault_status = '0;
         pending.delete();
         mismatches = 0;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] res;
         logic [63:0] bitpos;
         res = 0;
         bitpos = 64'd1 << 62;
         while (bitpos > v) bitpos = bitpos >> 2;
         while (bitpos != 0) begin
            if (v >= res + bitpos) begin
               v = v - (res + bitpos);
               res = (res >> 1) + bitpos;
            end else begin
               res = res >> 1;
            end
            bitpos = bitpos >> 2;
         end
         return res;
      endfunction

      function logic signed [18:0] solve_celsius(logic [14:0] code);
         logic [63:0] ratio;
         logic signed [63:0] disc;
         logic signed [63:0] num;
         logic [63:0] mag;
         logic [63:0] root;
         logic neg;
         if (nominal_ohms == 0) begin
            ratio = 64'd1 << 31;
         end else begin
            ratio = ((64'(code) * 64'(reference_ohms)) << 24) / 64'(nominal_ohms);
            if (ratio > (64'd1 << 31)) ratio = 64'd1 << 31;
         end
         disc = $signed(64'd1758480889 << 24) - $signed(64'd231000000 * ratio);
         if (disc < 0) disc = 0;
         root = int_sqrt(disc);
         num = (64'sd160083968 - $signed(root)) * 64'sd1000;
         neg = num < 0;
         mag = neg ? 64'(-num) : 64'(num);
         mag = mag << FRAC_BITS;
         mag = (mag + 64'd23654400) / 64'd47308800;
         if (neg) return (mag > 64'd262144) ? -19'sd262144 : 19'(-$signed(mag));
         return (mag > 64'd262143) ? 19'sd262143 : 19'(mag);
      endfunction

      function void note_poll(logic rdy, logic [15:0] word, logic [7:0] fstat);
         reading_type r;
         r.fresh = 0;
         r.clear_request = 0;
         if (rdy) begin
            stored_fault_status = fstat;
            if (word[0]) r.clear_request = 1;
            else begin
               held_temperature = solve_celsius(word[15:1]);
               r.fresh = 1;
            end
         end
         r.temperature = held_temperature;
         r.held_fault_status = stored_fault_status;
         pending.push_back(r);
      endfunction

      function void check_reading(reading_type got);
         reading_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response t=%0d", got.temperature);
            return;
         end
         e = pending.pop_front();
         if (got.temperature !== e.temperature || got.fresh !== e.fresh ||
             got.clear_request !== e.clear_request ||
             got.held_fault_status !== e.held_fault_status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp t=%0d f=%b c=%b s=%h  got t=%0d f=%b c=%b s=%h",
                  e.temperature, e.fresh, e.clear_request, e.held_fault_status,
                  got.temperature, got.fresh, got.clear_request, got.held_fault_status);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   quiet_cycles;
   bit   timed_out;
   reading_scoreboard board;

   rtdc_req_if req_chan ();
   rtdc_rsp_if rsp_chan ();
   rtdc_csr_if csr_chan ();

   rtd_to_temperature_converter #(.TEMP_FRAC_BITS(FRAC_BITS)) u_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // response side: random stall, check on accept
   always @(posedge clock) begin
      reading_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.temperature = rsp_chan.temperature;
            got.fresh = rsp_chan.fresh;
            got.clear_request = rsp_chan.clear_request;
            got.held_fault_status = rsp_chan.held_fault_status;
            board.check_reading(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("[rtd_to_temperature_converter] ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [15:0] value);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 0;
      if (idx == rtdc_pkg::REG_REFERENCE_OHMS) board.reference_ohms = value;
      else board.nominal_ohms = value;
      @(posedge clock);
   endtask

   // valid stays high between back-to-back requests, drops only while idling
   task automatic send_poll(logic rdy, logic [15:0] word, logic [7:0] fstat);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid <= 1;
      req_chan.data_ready <= rdy;
      req_chan.rtd_word <= word;
      req_chan.fault_status <= fstat;
      do @(posedge clock); while (!req_chan.ready);
      board.note_poll(rdy, word, fstat);
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // mostly clean samples, some near the useful range, some faults and idle polls
   task automatic random_polls(int count);
      logic [15:0] word;
      int kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         word = 16'($urandom());
         if (kind < 60) word[0] = 0;
         else if (kind < 75) word = {15'($urandom_range(5000, 14000)), 1'b0};
         send_poll(kind < 90 ? 1'b1 : 1'b0, word, 8'($urandom()));
      end
   endtask

   initial begin
      req_chan.valid = 0;
      req_chan.data_ready = 0;
      req_chan.rtd_word = 0;
      req_chan.fault_status = 0;
      csr_chan.valid = 0;
      csr_chan.index = rtdc_pkg::REG_REFERENCE_OHMS;
      csr_chan.data = 0;
      board = new();
      board.clear_state();
      send_idle_pct = 20;
      recv_idle_pct = 70;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, extremes, faults, not-ready, negative discriminant
      send_poll(0, 16'hFFFF, 8'hFF);
      send_poll(1, 16'h0000, 8'h00);
      send_poll(1, 16'hFFFE, 8'hA5);
      send_poll(1, 16'h0001, 8'hFF);
      send_poll(0, 16'h0000, 8'h00);
      send_poll(1, {15'd7620, 1'b0}, 8'h5A);
      send_poll(1, {15'd9000, 1'b0}, 8'h00);
      send_poll(1, 16'hFFFF, 8'h81);
      drain();
      write_reg(rtdc_pkg::REG_REFERENCE_OHMS, 16'hFFFF);
      write_reg(rtdc_pkg::REG_NOMINAL_OHMS, 16'd1);
      send_poll(1, 16'hFFFE, 8'h01);
      send_poll(1, 16'h0002, 8'h02);
      drain();
      write_reg(rtdc_pkg::REG_REFERENCE_OHMS, 16'd1);
      write_reg(rtdc_pkg::REG_NOMINAL_OHMS, 16'hFFFF);
      send_poll(1, 16'hFFFE, 8'h03);
      send_poll(1, 16'h0002, 8'h04);
      drain();
      write_reg(rtdc_pkg::REG_REFERENCE_OHMS, 16'd4300);
      write_reg(rtdc_pkg::REG_NOMINAL_OHMS, 16'd1000);
      send_poll(1, {15'd8000, 1'b0}, 8'h10);
      random_polls(130);

      drain();
      send_idle_pct = 70;
      recv_idle_pct = 20;
      write_reg(rtdc_pkg::REG_REFERENCE_OHMS, 16'd430);
      write_reg(rtdc_pkg::REG_NOMINAL_OHMS, 16'd100);
      random_polls(150);

      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(rtdc_pkg::REG_REFERENCE_OHMS, 16'($urandom_range(1, 65535)));
      write_reg(rtdc_pkg::REG_NOMINAL_OHMS, 16'($urandom_range(1, 65535)));
      random_polls(50);
      drain();
      write_reg(rtdc_pkg::REG_REFERENCE_OHMS, 16'd400);
      write_reg(rtdc_pkg::REG_NOMINAL_OHMS, 16'd100);
      random_polls(100);

      drain();
      if (board.mismatches == 0)
         $display("[rtd_to_temperature_converter] OK");
      else
         $display("[rtd_to_temperature_converter] ERROR");
      $finish;
   end
endmodule

>>> rtd_to_temperature_converter.f
sv/rtdc_pkg.sv
sv/rtdc_if.sv
sv/rtdc_div.sv
sv/rtdc_datapath.sv
sv/rtdc_ctrl.sv
sv/rtd_to_temperature_converter.sv
test/tb_rtd_to_temperature_converter.sv
